// ----- sv/elsm_pkg.sv -----
// ----------------------------------------------------------------------------
// elsm_pkg
// shared widths and control types for the edge list sort and merge block
// ----------------------------------------------------------------------------
package elsm_pkg;

  localparam int VTX_W      = 20;   // own_vertex, neighbour_id, out_neighbour
  localparam int WT_IN_W    = 16;   // edge_weight
  localparam int MW_W       = 21;   // merged_weight
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

// ----- sv/edge_list_sort_merge.sv -----
// ----------------------------------------------------------------------------
// edge_list_sort_merge
// collects one vertex's edge list, then emits unique neighbours in ascending
// order with summed weights, self-edges removed
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                         | tuser / tlast
//  s_axis  | in  | own_vertex, neighbour_id, edge_weight      | has_edge / last_edge
//  m_axis  | out | out_neighbour, merged_weight, zero pad     | out_valid, overflow / out_last
//
// loading takes one edge per cycle into the edge memory. after the last
// transfer the memory is scanned once per distinct neighbour, plus a final
// pass that finds none; each pass makes one read per cycle through the
// registered read port. the pass length is set by the single read port of
// the edge memory. reset is synchronous and clears control state only. a
// stalled result holds the scan at the end of its pass until the output
// register frees.
// ----------------------------------------------------------------------------
module edge_list_sort_merge
  import elsm_pkg::*;
#(
  parameter int MAX_EDGES   = 32,
  parameter int ID_BITS     = 20,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // own_vertex, neighbour_id, edge_weight
  input  logic                  s_axis_tuser,   // has_edge
  input  logic                  s_axis_tlast,   // last_edge
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_neighbour, merged_weight, zero pad
  output logic [1:0]            m_axis_tuser,   // out_valid, overflow
  output logic                  m_axis_tlast    // out_last
);

  localparam int CW  = $clog2(MAX_EDGES + 1);
  localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ACW = WEIGHT_BITS + 7;
  localparam int EW  = ID_BITS + WEIGHT_BITS;
  localparam logic [63:0] MW_MAX = (64'd1 << MW_W) - 64'd1;

  state_t state;

  logic [EW-1:0] mem [MAX_EDGES];
  logic [EW-1:0] rdata;

  logic [CW-1:0]          count;
  logic [CW-1:0]          n_edges;
  logic [CW-1:0]          rd_addr;
  logic                   rd_vld;
  logic                   ovf_seen;
  logic                   ovf_list;
  logic [ID_BITS-1:0]     owner;

  logic                   found;
  logic [ID_BITS-1:0]     min_id;
  logic [ACW-1:0]         acc;
  logic                   have_prev;
  logic [ID_BITS-1:0]     prev_id;

  logic                   pend_vld;
  logic [ID_BITS-1:0]     pend_id;
  logic [ACW-1:0]         pend_w;

  // field extraction, sized to the parameters
  logic [31:0]            nb_ext, own_ext, wt_ext;
  logic [ID_BITS-1:0]     in_id, in_own;
  logic [WEIGHT_BITS-1:0] in_wt;
  logic [ID_BITS-1:0]     r_id;
  logic [WEIGHT_BITS-1:0] r_wt;
  logic [ACW-1:0]         acc_sum;
  logic [63:0]            pend_id_ext, pend_w_ext;
  logic [MW_W-1:0]        pend_w_sat;
  logic [VTX_W-1:0]       pend_nb;

  logic s_xfer, out_free, pass_end, store_ok, out_load;

  assign nb_ext  = {{(32-VTX_W){1'b0}}, s_axis_tdata[2*VTX_W-1:VTX_W]};
  assign own_ext = {{(32-VTX_W){1'b0}}, s_axis_tdata[VTX_W-1:0]};
  assign wt_ext  = {{(32-WT_IN_W){1'b0}}, s_axis_tdata[2*VTX_W+WT_IN_W-1:2*VTX_W]};
  assign in_id   = nb_ext[ID_BITS-1:0];
  assign in_own  = own_ext[ID_BITS-1:0];
  assign in_wt   = wt_ext[WEIGHT_BITS-1:0];

  assign r_id    = rdata[EW-1:WEIGHT_BITS];
  assign r_wt    = rdata[WEIGHT_BITS-1:0];
  assign acc_sum = acc + {{(ACW-WEIGHT_BITS){1'b0}}, r_wt};

  assign pend_id_ext = {{(64-ID_BITS){1'b0}}, pend_id};
  assign pend_w_ext  = {{(64-ACW){1'b0}}, pend_w};
  assign pend_nb     = pend_id_ext[VTX_W-1:0];
  assign pend_w_sat  = (pend_w_ext > MW_MAX) ? MW_MAX[MW_W-1:0] : pend_w_ext[MW_W-1:0];

  assign s_axis_tready = (state == S_LOAD);
  assign s_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign pass_end = (rd_addr == n_edges) && !rd_vld;
  assign store_ok = s_axis_tuser && (count < CW'(MAX_EDGES));
  // output register loads a result this cycle
  assign out_load = out_free &&
                    ((state == S_DONE) ||
                     ((state == S_SCAN) && pass_end && found && (min_id != owner) &&
                      pend_vld));

  // edge memory: one write port for loading, one registered read port
  always_ff @(posedge clk) begin
    if (s_xfer && store_ok) begin
      mem[count[AW-1:0]] <= {in_id, in_wt};
    end
    if (state == S_SCAN && rd_addr < n_edges) begin
      rdata <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      count         <= '0;
      ovf_seen      <= 1'b0;
      owner         <= '0;
      rd_vld        <= 1'b0;
      rd_addr       <= '0;
      found         <= 1'b0;
      have_prev     <= 1'b0;
      pend_vld      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (s_xfer) begin
            owner <= in_own;
            if (s_axis_tlast) begin
              n_edges   <= store_ok ? count + CW'(1) : count;
              ovf_list  <= ovf_seen || (s_axis_tuser && !store_ok);
              count     <= '0;
              ovf_seen  <= 1'b0;
              rd_addr   <= '0;
              rd_vld    <= 1'b0;
              found     <= 1'b0;
              have_prev <= 1'b0;
              pend_vld  <= 1'b0;
              state     <= (store_ok || count != '0) ? S_SCAN : S_DONE;
            end else if (store_ok) begin
              count <= count + CW'(1);
            end else if (s_axis_tuser) begin
              ovf_seen <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (rd_addr < n_edges) begin
            rd_addr <= rd_addr + CW'(1);
            rd_vld  <= 1'b1;
          end else begin
            rd_vld <= 1'b0;
          end
          // smallest id above the last one found, weights of equal ids summed
          if (rd_vld && (!have_prev || r_id > prev_id)) begin
            if (!found || r_id < min_id) begin
              found  <= 1'b1;
              min_id <= r_id;
              acc    <= {{(ACW-WEIGHT_BITS){1'b0}}, r_wt};
            end else if (r_id == min_id) begin
              acc <= acc_sum;
            end
          end
          if (pass_end) begin
            if (!found) begin
              state <= S_DONE;
            end else if (min_id == owner) begin
              // self-edge: skip it and scan again
              prev_id   <= min_id;
              have_prev <= 1'b1;
              found     <= 1'b0;
              rd_addr   <= '0;
            end else if (!pend_vld || out_free) begin
              if (pend_vld) begin
                m_axis_tdata  <= {{(OUT_DATA_W-VTX_W-MW_W){1'b0}}, pend_w_sat, pend_nb};
                m_axis_tuser  <= {ovf_list, 1'b1};
                m_axis_tlast  <= 1'b0;
              end
              pend_vld  <= 1'b1;
              pend_id   <= min_id;
              pend_w    <= acc;
              prev_id   <= min_id;
              have_prev <= 1'b1;
              found     <= 1'b0;
              rd_addr   <= '0;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_axis_tlast  <= 1'b1;
            m_axis_tuser  <= {ovf_list, pend_vld};
            if (pend_vld) begin
              m_axis_tdata <= {{(OUT_DATA_W-VTX_W-MW_W){1'b0}}, pend_w_sat, pend_nb};
            end else begin
              m_axis_tdata <= '0;
            end
            pend_vld <= 1'b0;
            state    <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule
